FILE: src/ice_pkg.sv
package ice_pkg;

  typedef logic [1:0]  mode_t;
  typedef logic [3:0]  index_t;
  typedef logic [15:0] word_t;

  localparam logic    OP_HEADER = 1'b0;
  localparam logic    OP_DATA   = 1'b1;

  localparam mode_t   MODE_PLAIN = 2'd0;
  localparam mode_t   MODE_TCP   = 2'd1;
  localparam mode_t   MODE_UDP   = 2'd2;

  localparam word_t   PROTO_TCP = 16'd6;
  localparam word_t   PROTO_UDP = 16'd17;

  localparam index_t  TCP_CHECK_WORD = 4'd8;
  localparam index_t  UDP_CHECK_WORD = 4'd3;
  localparam index_t  INDEX_MAX      = 4'd15;

  localparam word_t   ODD_BYTE_MASK = 16'hFF00;
  localparam word_t   SUM_ZERO      = 16'h0000;
  localparam word_t   SUM_ONES      = 16'hFFFF;

endpackage

FILE: src/internet_checksum_engine.sv
// Streaming Internet checksum: one word enters per cycle unless in_stall
// is high; a packet's last word is held in the input register and its
// checksum in the result register. A header word starts a packet in plain,
// TCP or UDP mode and in TCP and UDP mode preloads the pseudo-header sum;
// in TCP and UDP mode the embedded checksum word (word 8 or word 3) is
// counted as zero. The rate of one word per cycle is set by the single
// end-around-carry add that updates the running sum; an input register and
// a result register separate the two channels, so the block keeps taking
// words while a finished checksum waits, until another last word is held.
module internet_checksum_engine
  import ice_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [1:0]  in_proto_mode,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_seg_length,
  input  logic [15:0] in_data_word,
  input  logic        in_last,
  input  logic        in_odd_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum
);

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_op_r;
  mode_t       s1_mode_r;
  logic [31:0] s1_src_r;
  logic [31:0] s1_dst_r;
  word_t       s1_len_r;
  word_t       s1_word_r;
  logic        s1_last_r;
  logic        s1_odd_r;

  word_t       sum_r, sum_nxt;
  index_t      index_r, index_nxt;
  mode_t       mode_r, mode_nxt;

  logic        out_valid_r, out_valid_nxt;
  word_t       out_checksum_r, out_checksum_nxt;

  logic        in_fire;
  logic        s1_result;
  logic        s1_fire;
  logic        out_free;

  mode_t       hdr_mode;
  word_t       hdr_proto;
  logic [18:0] hdr_raw;
  logic [16:0] hdr_fold1;
  logic [15:0] hdr_fold2;
  word_t       hdr_sum;

  logic        zero_word;
  word_t       data_word;
  logic [16:0] data_raw;
  word_t       data_sum;
  word_t       data_cks;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_result = (s1_op_r == OP_DATA) && s1_last_r;
  assign s1_fire   = s1_valid_r && (!s1_result || out_free);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    hdr_mode = ((s1_mode_r == MODE_TCP) || (s1_mode_r == MODE_UDP)) ? s1_mode_r : MODE_PLAIN;
    hdr_proto = (hdr_mode == MODE_TCP) ? PROTO_TCP : PROTO_UDP;
    hdr_raw = {3'b0, s1_src_r[31:16]} + {3'b0, s1_src_r[15:0]} +
              {3'b0, s1_dst_r[31:16]} + {3'b0, s1_dst_r[15:0]} +
              {3'b0, hdr_proto} + {3'b0, s1_len_r};
    hdr_fold1 = {1'b0, hdr_raw[15:0]} + {14'b0, hdr_raw[18:16]};
    hdr_fold2 = hdr_fold1[15:0] + {15'b0, hdr_fold1[16]};
    hdr_sum = (hdr_mode == MODE_PLAIN) ? SUM_ZERO : hdr_fold2;
  end

  always_comb begin
    zero_word = ((mode_r == MODE_TCP) && (index_r == TCP_CHECK_WORD)) ||
                ((mode_r == MODE_UDP) && (index_r == UDP_CHECK_WORD));
    data_word = zero_word ? SUM_ZERO : s1_word_r;
    if (s1_last_r && s1_odd_r) begin
      data_word = data_word & ODD_BYTE_MASK;
    end
    data_raw = {1'b0, sum_r} + {1'b0, data_word};
    data_sum = data_raw[15:0] + {15'b0, data_raw[16]};
    data_cks = ~data_sum;
    if ((mode_r == MODE_UDP) && (data_cks == SUM_ZERO)) begin
      data_cks = SUM_ONES;
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    index_nxt = index_r;
    mode_nxt = mode_r;
    if (s1_fire) begin
      if (s1_op_r == OP_HEADER) begin
        sum_nxt = hdr_sum;
        index_nxt = '0;
        mode_nxt = hdr_mode;
      end else if (s1_last_r) begin
        sum_nxt = SUM_ZERO;
        index_nxt = '0;
        mode_nxt = MODE_PLAIN;
      end else begin
        sum_nxt = data_sum;
        index_nxt = (index_r < INDEX_MAX) ? index_r + 4'd1 : index_r;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = in_fire || (s1_valid_r && !s1_fire);
    out_valid_nxt = out_valid_r;
    out_checksum_nxt = out_checksum_r;
    if (out_free) begin
      out_valid_nxt = s1_fire && s1_result;
      if (s1_fire && s1_result) begin
        out_checksum_nxt = data_cks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r <= SUM_ZERO;
      index_r <= '0;
      mode_r <= MODE_PLAIN;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r <= sum_nxt;
      index_r <= index_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r <= in_op;
      s1_mode_r <= in_proto_mode;
      s1_src_r <= in_src_addr;
      s1_dst_r <= in_dst_addr;
      s1_len_r <= in_seg_length;
      s1_word_r <= in_data_word;
      s1_last_r <= in_last;
      s1_odd_r <= in_odd_byte;
    end
    out_checksum_r <= out_checksum_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_checksum = out_checksum_r;

endmodule

FILE: src/ice_checker.sv
module ice_checker
  import ice_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_op,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_checksum
);

  // A last word with a free result side yields a checksum through the input and result registers.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == OP_DATA) && in_last) ##1 !out_stall |=> out_valid)
    else $error("last word did not produce a checksum");

  // The input side only waits while a finished checksum is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // Reset leaves both channels empty and open.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("channels not clear after reset");

  // A stalled checksum stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_checksum)))
    else $error("stalled checksum changed");

endmodule

bind internet_checksum_engine ice_checker u_ice_checker (.*);

FILE: dv/checksum_monitor.sv
module checksum_monitor
  import ice_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_op,
  input  logic [1:0]  in_proto_mode,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_seg_length,
  input  logic [15:0] in_data_word,
  input  logic        in_last,
  input  logic        in_odd_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_checksum,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  word_t  sum_acc;
  index_t word_idx;
  mode_t  pkt_mode;
  word_t  pending_checksums[$];
  int     n_bad  = 0;
  int     n_open = 0;

  assign mismatches  = n_bad;
  assign outstanding = n_open;

  function automatic word_t ones_add(word_t a, word_t b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic word_t pseudo_sum(mode_t m, logic [31:0] src, logic [31:0] dst,
                                       word_t len);
    word_t s;
    s = ones_add(SUM_ZERO, src[31:16]);
    s = ones_add(s, src[15:0]);
    s = ones_add(s, dst[31:16]);
    s = ones_add(s, dst[15:0]);
    s = ones_add(s, (m == MODE_TCP) ? PROTO_TCP : PROTO_UDP);
    s = ones_add(s, len);
    return s;
  endfunction

  always @(posedge clk) begin : track
    word_t w;
    word_t cks;
    if (!rst_n) begin
      sum_acc  = SUM_ZERO;
      word_idx = '0;
      pkt_mode = MODE_PLAIN;
      pending_checksums.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_checksums.size() == 0) begin
          $display("%0t: checksum %h arrived with none expected", $time, out_checksum);
          n_bad++;
        end else begin
          cks = pending_checksums.pop_front();
          if (out_checksum !== cks) begin
            $display("%0t: checksum mismatch, expected %h, actual %h",
                     $time, cks, out_checksum);
            n_bad++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_op == OP_HEADER) begin
          pkt_mode = (in_proto_mode == MODE_TCP || in_proto_mode == MODE_UDP) ?
                     mode_t'(in_proto_mode) : MODE_PLAIN;
          word_idx = '0;
          sum_acc  = (pkt_mode == MODE_PLAIN) ? SUM_ZERO :
                     pseudo_sum(pkt_mode, in_src_addr, in_dst_addr, in_seg_length);
        end else begin
          w = in_data_word;
          if ((pkt_mode == MODE_TCP && word_idx == TCP_CHECK_WORD) ||
              (pkt_mode == MODE_UDP && word_idx == UDP_CHECK_WORD)) begin
            w = SUM_ZERO;
          end
          if (in_last && in_odd_byte) begin
            w = w & ODD_BYTE_MASK;
          end
          sum_acc = ones_add(sum_acc, w);
          if (word_idx < INDEX_MAX) begin
            word_idx = word_idx + 4'd1;
          end
          if (in_last) begin
            cks = ~sum_acc;
            if (pkt_mode == MODE_UDP && cks == SUM_ZERO) begin
              cks = SUM_ONES;
            end
            pending_checksums.push_back(cks);
            sum_acc  = SUM_ZERO;
            word_idx = '0;
            pkt_mode = MODE_PLAIN;
          end
        end
      end
    end
    n_open = pending_checksums.size();
  end

endmodule

FILE: dv/tb_internet_checksum_engine.sv
module tb_internet_checksum_engine;
  import ice_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int    IDLE_LIMIT  = 2000;
  localparam int    PHASE_WORDS = 470;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [1:0]  in_proto_mode;
  logic [31:0] in_src_addr;
  logic [31:0] in_dst_addr;
  logic [15:0] in_seg_length;
  logic [15:0] in_data_word;
  logic        in_last;
  logic        in_odd_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_checksum;

  int mismatches;
  int outstanding;
  int words_sent   = 0;
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int idle_cycles  = 0;

  internet_checksum_engine u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_proto_mode(in_proto_mode),
    .in_src_addr  (in_src_addr),
    .in_dst_addr  (in_dst_addr),
    .in_seg_length(in_seg_length),
    .in_data_word (in_data_word),
    .in_last      (in_last),
    .in_odd_byte  (in_odd_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

  checksum_monitor u_monitor (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_proto_mode(in_proto_mode),
    .in_src_addr  (in_src_addr),
    .in_dst_addr  (in_dst_addr),
    .in_seg_length(in_seg_length),
    .in_data_word (in_data_word),
    .in_last      (in_last),
    .in_odd_byte  (in_odd_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic word_t rand_word();
    int r;
    r = $urandom_range(9);
    if (r == 0) return SUM_ZERO;
    if (r == 1) return SUM_ONES;
    return word_t'($urandom);
  endfunction

  function automatic logic [31:0] rand_addr();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_word(input logic op, input mode_t mode, input logic [31:0] src,
                           input logic [31:0] dst, input word_t len, input word_t data,
                           input logic last, input logic odd);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_proto_mode <= mode;
    in_src_addr   <= src;
    in_dst_addr   <= dst;
    in_seg_length <= len;
    in_data_word  <= data;
    in_last       <= last;
    in_odd_byte   <= odd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic random_packet();
    int    r;
    int    n;
    mode_t m;
    r = $urandom_range(99);
    if (r < 85) begin
      if ($urandom_range(99) < 90) begin
        r = $urandom_range(99);
        m = (r < 40) ? MODE_TCP : (r < 80) ? MODE_UDP : (r < 95) ? MODE_PLAIN : MODE_UNUSED;
        send_word(OP_HEADER, m, rand_addr(), rand_addr(), word_t'($urandom_range(65535)),
                  word_t'($urandom), logic'($urandom_range(1)), logic'($urandom_range(1)));
      end
      n = ($urandom_range(99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 40);
      for (int i = 0; i < n; i++) begin
        send_word(OP_DATA, mode_t'($urandom_range(3)), rand_addr(), rand_addr(),
                  word_t'($urandom_range(65535)), rand_word(), (i == n - 1),
                  logic'($urandom_range(1)));
      end
    end else begin
      send_word(logic'($urandom_range(1)), mode_t'($urandom_range(3)), rand_addr(),
                rand_addr(), word_t'($urandom_range(65535)), rand_word(),
                ($urandom_range(3) == 0), logic'($urandom_range(1)));
    end
  endtask

  task automatic random_phase(input int gap, input int stall);
    int start;
    send_gap_pct = gap;
    stall_pct    = stall;
    start        = words_sent;
    while (words_sent - start < PHASE_WORDS) random_packet();
    drain();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= OP_HEADER;
    in_proto_mode <= MODE_PLAIN;
    in_src_addr   <= '0;
    in_dst_addr   <= '0;
    in_seg_length <= '0;
    in_data_word  <= '0;
    in_last       <= 1'b0;
    in_odd_byte   <= 1'b0;
    send_gap_pct  = 7;
    stall_pct     = 56;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // A lone last word right after reset is a complete plain packet.
    send_word(OP_DATA, MODE_PLAIN, '0, '0, '0, SUM_ONES, 1'b1, 1'b0);
    send_word(OP_HEADER, MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SUM_ONES, SUM_ONES,
              1'b1, 1'b1);
    send_word(OP_DATA, MODE_UDP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SUM_ONES, 16'h1234,
              1'b0, 1'b1);
    send_word(OP_DATA, MODE_TCP, '0, '0, '0, 16'hABCD, 1'b1, 1'b1);
    send_word(OP_HEADER, MODE_TCP, 32'hFFFF_FFFF, 32'h0000_0000, SUM_ONES, SUM_ZERO,
              1'b0, 1'b0);
    for (int i = 0; i < 10; i++) begin
      send_word(OP_DATA, MODE_PLAIN, '0, '0, '0, 16'h8000 + word_t'(i * 16'h0111),
                (i == 9), 1'b0);
    end
    // UDP sum of all ones must come out as 0xFFFF rather than zero.
    send_word(OP_HEADER, MODE_UDP, '0, '0, SUM_ZERO, '0, 1'b0, 1'b0);
    send_word(OP_DATA, MODE_PLAIN, '0, '0, '0, 16'hFFEE, 1'b1, 1'b0);
    send_word(OP_HEADER, MODE_UDP, rand_addr(), rand_addr(), 16'd1500, '0, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) begin
      send_word(OP_DATA, MODE_PLAIN, '0, '0, '0, rand_word(), (i == 3), 1'b1);
    end
    drain();

    random_phase(7, 56);
    random_phase(56, 7);
    random_phase(0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
